// ===== hdl/rayobb_pkg.sv =====
// Shared constants, types and saturation helpers for the ray/oriented-box slab test.
// Used by the top level, the divider and the checker; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package rayobb_pkg;

	localparam int FRAC_BITS = 12;
	localparam int VAL_W     = 32;
	localparam int DIST_W    = 31;
	localparam int EPS_W     = 16;
	localparam int IN_W      = 8 * VAL_W;
	localparam int OUT_W     = 32;
	localparam int CFG_IDX_W = 3;
	// Dot product accumulator: three products shifted right by FRAC_BITS, summed exactly.
	localparam int ACC_W     = 2 * VAL_W - FRAC_BITS + 2;
	// Divider numerator magnitude: |e + bound| scaled by 2^FRAC_BITS.
	localparam int NUM_W     = VAL_W + 1 + FRAC_BITS;
	localparam int DCNT_W    = $clog2(NUM_W + 1);

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic [NUM_W-1:0]        num_t;
	typedef logic [VAL_W-1:0]        den_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_DIR_X    = 3'd3,
		REG_DIR_Y    = 3'd4,
		REG_DIR_Z    = 3'd5,
		REG_FAR      = 3'd6,
		REG_EPS      = 3'd7
	} reg_idx_t;

	localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	function automatic val_t sat_acc(input acc_t v);
		if (v > acc_t'(VAL_MAX))
			return VAL_MAX;
		else if (v < acc_t'(VAL_MIN))
			return VAL_MIN;
		else
			return v[VAL_W-1:0];
	endfunction

	function automatic val_t sat_diff(input logic signed [VAL_W:0] v);
		if (v[VAL_W] != v[VAL_W-1])
			return v[VAL_W] ? VAL_MIN : VAL_MAX;
		else
			return v[VAL_W-1:0];
	endfunction

	// Applies the sign to an unsigned quotient magnitude and clamps to 32 bits.
	function automatic val_t sat_quot(input num_t q, input logic neg);
		num_t lim;
		lim = NUM_W'({1'b0, VAL_MAX});
		if (!neg) begin
			if (q > lim)
				return VAL_MAX;
			else
				return q[VAL_W-1:0];
		end else begin
			if (q > lim + NUM_W'(1))
				return VAL_MIN;
			else
				return val_t'(-q[VAL_W-1:0]);
		end
	endfunction

endpackage

`default_nettype wire

// ===== hdl/rayobb_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on rayobb_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none

module rayobb_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire rayobb_pkg::num_t  num,
	input  wire rayobb_pkg::den_t  den,
	output logic                   done,
	output rayobb_pkg::num_t       quot
);
	import rayobb_pkg::*;

	num_t              shreg_q;
	den_t              den_q;
	logic [VAL_W-1:0]  rem_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              done_q;
	logic [VAL_W:0]    trial;
	logic              fits;

	assign trial = {rem_q, shreg_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= DCNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - DCNT_W'(1);
				if (cnt_q == DCNT_W'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shreg_q <= num;
			den_q   <= den;
			rem_q   <= '0;
		end else if (cnt_q != '0) begin
			// Remainder stays below the divisor, so it always fits in VAL_W bits.
			rem_q   <= fits ? VAL_W'(trial - {1'b0, den_q}) : trial[VAL_W-1:0];
			shreg_q <= {shreg_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = shreg_q;

endmodule

`default_nettype wire

// ===== hdl/ray_obb_slab_intersection_top.sv =====
// Top level of the ray/oriented-box slab test: configuration registers, sequencer,
// shared multiplier and running near/far state. Depends on rayobb_pkg and rayobb_div.
//
//  Channel  Direction  Signals                     Contents
//  s_*      in         tvalid tready tdata tlast   one box axis per item, tlast = last_axis
//  m_*      out        tvalid tready tdata         one result per box: hit, distance
//  cfg_*    in         we index data               ray, far limit, parallel threshold
//
// Each plane division runs on a restoring divider at one bit per cycle over 45
// numerator bits, and the six dot product terms share one multiplier. A parallel
// axis skips the divisions; an item of a box that has already missed skips the dot
// products and divisions. s_tready is high only while the sequencer is idle.
// A finished result waits in the output register; the next box result holds the
// sequencer until that register has been taken. Reset is asynchronous, active low.
`timescale 1ns / 1ps
`default_nettype none

module ray_obb_slab_intersection_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// axis_x, axis_y, axis_z, center_x, center_y, center_z, slab_min, slab_max
	input  wire logic [rayobb_pkg::IN_W-1:0]     s_tdata,
	input  wire logic                            s_tlast,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// hit, distance
	output logic [rayobb_pkg::OUT_W-1:0]         m_tdata,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	input  wire logic                            cfg_we,
	input  wire logic [rayobb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rayobb_pkg::VAL_W-1:0]    cfg_data
);
	import rayobb_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_DELTA  = 9'b000000010,
		S_MUL    = 9'b000000100,
		S_CHECK  = 9'b000001000,
		S_DIV1   = 9'b000010000,
		S_DIV2   = 9'b000100000,
		S_UPDATE = 9'b001000000,
		S_CMP    = 9'b010000000,
		S_FINISH = 9'b100000000
	} state_t;

	state_t state_q;

	// Configuration
	val_t             origin_q [3];
	val_t             dir_q [3];
	logic [DIST_W-1:0] far_limit_q;
	logic [EPS_W-1:0] eps_q;

	// Item registers
	val_t axis_q [3];
	val_t center_q [3];
	val_t delta_q [3];
	val_t smin_q, smax_q;
	logic last_q;

	// Running box state
	val_t near_q, far_q;
	logic missed_q;

	// Dot products
	logic [2:0]             mcnt_q;
	val_t                   op_a, op_b;
	logic signed [2*VAL_W-1:0] prod_s1;
	acc_t                   acc_q;
	acc_t                   term;
	acc_t                   acc_sum;
	val_t                   e_q, f_q;
	val_t                   t1_q;

	// Division
	logic              div_start;
	num_t              div_num;
	den_t              div_den;
	logic              div_done;
	num_t              div_quot;
	logic signed [VAL_W:0] nsum;
	logic [VAL_W:0]    nmag;
	logic              qneg;
	logic              qneg_q;
	den_t              fmag;
	val_t              t_now;
	val_t              t_lo, t_hi;

	logic out_valid_q;
	logic out_hit_q;
	logic [DIST_W-1:0] out_dist_q;
	logic accept;
	logic out_free;
	logic out_load;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || m_tready;
	assign out_load = (state_q == S_FINISH) && last_q && out_free;

	always_comb begin
		case (mcnt_q)
			3'd0: begin op_a = axis_q[0]; op_b = delta_q[0]; end
			3'd1: begin op_a = axis_q[1]; op_b = delta_q[1]; end
			3'd2: begin op_a = axis_q[2]; op_b = delta_q[2]; end
			3'd3: begin op_a = dir_q[0];  op_b = axis_q[0];  end
			3'd4: begin op_a = dir_q[1];  op_b = axis_q[1];  end
			3'd5: begin op_a = dir_q[2];  op_b = axis_q[2];  end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end

	// Arithmetic shift rounds each product toward minus infinity.
	assign term    = ACC_W'(prod_s1 >>> FRAC_BITS);
	assign acc_sum = acc_q + term;

	assign fmag    = f_q[VAL_W-1] ? den_t'(-f_q) : den_t'(f_q);
	assign qneg    = nsum[VAL_W] ^ f_q[VAL_W-1];
	assign nmag    = nsum[VAL_W] ? (VAL_W+1)'(-nsum) : (VAL_W+1)'(nsum);
	assign div_num = {nmag, {FRAC_BITS{1'b0}}};
	assign div_den = fmag;
	// The quotient sign is captured when its division starts.
	assign t_now   = sat_quot(div_quot, qneg_q);
	assign t_lo    = (t1_q > t_now) ? t_now : t1_q;
	assign t_hi    = (t1_q > t_now) ? t1_q : t_now;

	always_comb begin
		if (state_q == S_DIV1)
			nsum = {smax_q[VAL_W-1], smax_q} + {e_q[VAL_W-1], e_q};
		else
			nsum = {smin_q[VAL_W-1], smin_q} + {e_q[VAL_W-1], e_q};
	end

	assign div_start = ((state_q == S_CHECK) && (fmag > den_t'(eps_q)) && !missed_q)
		|| ((state_q == S_DIV1) && div_done);

	rayobb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		if (accept) begin
			for (int i = 0; i < 3; i++) begin
				axis_q[i]   <= s_tdata[i*VAL_W +: VAL_W];
				center_q[i] <= s_tdata[(i+3)*VAL_W +: VAL_W];
			end
			smin_q <= s_tdata[6*VAL_W +: VAL_W];
			smax_q <= s_tdata[7*VAL_W +: VAL_W];
			last_q <= s_tlast;
		end
		if (state_q == S_DELTA) begin
			for (int i = 0; i < 3; i++)
				delta_q[i] <= sat_diff({center_q[i][VAL_W-1], center_q[i]}
					- {origin_q[i][VAL_W-1], origin_q[i]});
		end
		if (state_q == S_MUL && mcnt_q == 3'd3)
			e_q <= sat_acc(acc_sum);
		if (state_q == S_MUL && mcnt_q == 3'd6)
			f_q <= sat_acc(acc_sum);
		if (div_start)
			qneg_q <= qneg;
		if (state_q == S_DIV1 && div_done)
			t1_q <= t_now;
		if (out_load) begin
			out_hit_q  <= !missed_q;
			out_dist_q <= missed_q ? '0 : near_q[DIST_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mcnt_q      <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			near_q      <= '0;
			far_q       <= val_t'(32'd409600000);
			missed_q    <= 1'b0;
			origin_q[0] <= '0;
			origin_q[1] <= '0;
			origin_q[2] <= '0;
			dir_q[0]    <= '0;
			dir_q[1]    <= '0;
			dir_q[2]    <= val_t'(32'd4096);
			far_limit_q <= DIST_W'(409600000);
			eps_q       <= EPS_W'(4);
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= S_DELTA;
				end
				S_DELTA: begin
					mcnt_q  <= '0;
					acc_q   <= '0;
					state_q <= missed_q ? S_FINISH : S_MUL;
				end
				S_MUL: begin
					mcnt_q <= mcnt_q + 3'd1;
					if (mcnt_q == 3'd3)
						acc_q <= '0;
					else if (mcnt_q != 3'd0)
						acc_q <= acc_sum;
					if (mcnt_q == 3'd6)
						state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (fmag > den_t'(eps_q)) begin
						state_q <= S_DIV1;
					end else begin
						if (smin_q > e_q || smax_q < e_q)
							missed_q <= 1'b1;
						state_q <= S_FINISH;
					end
				end
				S_DIV1: begin
					if (div_done)
						state_q <= S_DIV2;
				end
				S_DIV2: begin
					if (div_done) begin
						if (t_hi < far_q)
							far_q <= t_hi;
						if (t_lo > near_q)
							near_q <= t_lo;
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (far_q < near_q)
						missed_q <= 1'b1;
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						near_q      <= '0;
						far_q       <= val_t'({1'b0, far_limit_q});
						missed_q    <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_ORIGIN_X: origin_q[0] <= cfg_data;
					REG_ORIGIN_Y: origin_q[1] <= cfg_data;
					REG_ORIGIN_Z: origin_q[2] <= cfg_data;
					REG_DIR_X:    dir_q[0]    <= cfg_data;
					REG_DIR_Y:    dir_q[1]    <= cfg_data;
					REG_DIR_Z:    dir_q[2]    <= cfg_data;
					REG_FAR: begin
						// The running far distance follows a new limit at once.
						far_limit_q <= cfg_data[DIST_W-1:0];
						far_q       <= val_t'({1'b0, cfg_data[DIST_W-1:0]});
					end
					REG_EPS:      eps_q       <= cfg_data[EPS_W-1:0];
					default: ;
				endcase
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_dist_q, out_hit_q};

endmodule

`default_nettype wire

// ===== hdl/rayobb_chk.sv =====
// Port-level checks for the ray/oriented-box slab test, bound to the top level.
// Depends on rayobb_pkg for port widths.
`timescale 1ns / 1ps
`default_nettype none

module rayobb_chk (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_tvalid,
	input wire logic                             s_tready,
	input wire logic [rayobb_pkg::OUT_W-1:0]     m_tdata,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready
);
	import rayobb_pkg::*;

	// A result waiting for the sink keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// The sequencer works on one item at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while busy");

	// A miss reports a zero distance.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[OUT_W-1:1] == '0)
		else $error("miss with nonzero distance");

	// A new result appears only when the sequencer returns to idle.
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result raised while busy");

endmodule

bind ray_obb_slab_intersection_top rayobb_chk u_rayobb_chk (.*);

`default_nettype wire
